/* src/file_type_magic_sniffer_unit_defines.svh */
// Assertion macros for the file type sniffer.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef FILE_TYPE_MAGIC_SNIFFER_UNIT_DEFINES_SVH
`define FILE_TYPE_MAGIC_SNIFFER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define FTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/fts_pkg.sv */
// Shared types, type codes and magic byte constants of the file type sniffer.
// No dependencies.
`default_nettype none

package fts_pkg;

  // Number of leading bytes kept for magic matching
  localparam int unsigned HDR_KEEP  = 5;
  localparam int unsigned HDR_IDX_W = 3;

  typedef logic [HDR_KEEP-1:0][7:0] hdr_t;

  typedef enum logic [3:0] {
    TYPE_UNKNOWN = 4'd0,
    TYPE_JPG     = 4'd1,
    TYPE_PNG     = 4'd2,
    TYPE_PDF     = 4'd3,
    TYPE_ZIP     = 4'd4,
    TYPE_PS      = 4'd5,
    TYPE_GIF     = 4'd6,
    TYPE_TIF     = 4'd7,
    TYPE_ELF     = 4'd8,
    TYPE_TXT     = 4'd9,
    TYPE_DAT     = 4'd10
  } type_code_e;

  localparam logic [7:0] B_00   = 8'h00;
  localparam logic [7:0] B_03   = 8'h03;
  localparam logic [7:0] B_04   = 8'h04;
  localparam logic [7:0] B_BANG = 8'h21;
  localparam logic [7:0] B_PCT  = 8'h25;
  localparam logic [7:0] B_STAR = 8'h2A;
  localparam logic [7:0] B_DASH = 8'h2D;
  localparam logic [7:0] B_D    = 8'h44;
  localparam logic [7:0] B_E    = 8'h45;
  localparam logic [7:0] B_F    = 8'h46;
  localparam logic [7:0] B_G    = 8'h47;
  localparam logic [7:0] B_I    = 8'h49;
  localparam logic [7:0] B_K    = 8'h4B;
  localparam logic [7:0] B_L    = 8'h4C;
  localparam logic [7:0] B_M    = 8'h4D;
  localparam logic [7:0] B_N    = 8'h4E;
  localparam logic [7:0] B_P    = 8'h50;
  localparam logic [7:0] B_S    = 8'h53;
  localparam logic [7:0] B_DEL  = 8'h7F;
  localparam logic [7:0] B_89   = 8'h89;
  localparam logic [7:0] B_D8   = 8'hD8;
  localparam logic [7:0] B_FF   = 8'hFF;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Printable ASCII, tab, CR or LF
  function automatic logic is_text(input logic [7:0] b);
    return ((b >= CH_SPACE) && (b <= CH_TILDE)) ||
           (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

/* src/fts_if.sv */
// Valid/ready channel interfaces for the byte stream and the type result.
// Depends on nothing; payload widths are fixed.
`default_nettype none

interface fts_byte_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] buffer_length;
  logic        last_byte;

  modport source (output valid, output data_byte, output buffer_length,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input buffer_length,
                  input last_byte, output ready);
endinterface

interface fts_code_if ();
  logic       valid;
  logic       ready;
  logic [3:0] type_code;

  modport source (output valid, output type_code, input ready);
  modport sink   (input valid, input type_code, output ready);
endinterface

`default_nettype wire

/* src/file_type_magic_sniffer_unit.sv */
// Throughput: one byte transfer per cycle, sustained, while the result side keeps up.
// After the transfer of the last byte, the type code becomes valid once the byte has
//   passed the input register and the code has been loaded into the result register.
// A result waiting on the output stalls only the last byte of the next buffer.
// Reset (rst_ni low, asynchronous) empties both stages and clears the scan state.
// Depends on fts_pkg, fts_if, fts_scan, fts_classify and the assertion macro header.
`default_nettype none

`include "file_type_magic_sniffer_unit_defines.svh"

module file_type_magic_sniffer_unit #(
  parameter int unsigned SCAN_BYTES = 256,
  parameter int unsigned TEXT_CAP   = 240,
  parameter int unsigned MIN_LENGTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fts_byte_if.sink    byte_i,
  fts_code_if.source  type_o
);

  // Byte index and text count both reach SCAN_BYTES
  localparam int unsigned CNT_W = $clog2(SCAN_BYTES + 1);

  // Input register stage
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic [15:0] s1_len_q;
  logic        s1_last_q;

  // Result register stage
  logic                res_valid_q, res_valid_d;
  fts_pkg::type_code_e res_code_q;

  logic                res_free;
  logic                s1_fire;
  logic                in_xfer;
  fts_pkg::hdr_t       hdr;
  logic [CNT_W-1:0]    cnt;
  fts_pkg::type_code_e code;

  // A byte that is not the last only updates state, so it never waits on the
  // result side; the last byte moves only when the result register is free.
  assign res_free     = !res_valid_q || type_o.ready;
  assign s1_fire      = s1_valid_q && (!s1_last_q || res_free);
  assign byte_i.ready = !s1_valid_q || s1_fire;
  assign in_xfer      = byte_i.valid && byte_i.ready;

  // Control of the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  // Payload of the input stage: hold until the stage advances
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= byte_i.data_byte;
      s1_len_q  <= byte_i.buffer_length;
      s1_last_q <= byte_i.last_byte;
    end
  end

  fts_scan #(
    .SCAN_BYTES (SCAN_BYTES),
    .CNT_W      (CNT_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_fire),
    .last_i      (s1_last_q),
    .data_byte_i (s1_byte_q),
    .hdr_o       (hdr),
    .cnt_o       (cnt)
  );

  // Classify on the state that already includes the current byte
  fts_classify #(
    .CNT_W      (CNT_W),
    .TEXT_CAP   (TEXT_CAP),
    .MIN_LENGTH (MIN_LENGTH)
  ) u_classify (
    .hdr_i  (hdr),
    .cnt_i  (cnt),
    .len_i  (s1_len_q),
    .code_o (code)
  );

  // Load a new result on the last byte, drop the old one once it is taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (s1_fire && s1_last_q) begin
      res_valid_d = 1'b1;
    end else if (type_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_code_q <= code;
    end
  end

  assign type_o.valid     = res_valid_q;
  assign type_o.type_code = res_code_q;

  // A result shows up only after a last byte left the input stage
  `FTS_ASSERT(a_res_from_last, $rose(type_o.valid) |-> $past(s1_fire && s1_last_q), "result without last byte")
  // Every last byte that leaves the input stage produces a result
  `FTS_ASSERT(a_last_gives_res, (s1_fire && s1_last_q) |=> type_o.valid, "last byte produced no result")
  // A stalled input register means a pending last byte behind a full result stage
  `FTS_ASSERT(a_stall_cause, !byte_i.ready |-> (s1_valid_q && s1_last_q && res_valid_q), "unexpected input stall")
  // Nothing is offered while in reset
  `FTS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!type_o.valid && !s1_valid_q), "output valid in reset")

endmodule

`default_nettype wire

/* src/fts_scan.sv */
// Per-buffer scan state: header bytes, byte index and text byte count.
// Depends on fts_pkg.
`default_nettype none

module fts_scan #(
  parameter int unsigned SCAN_BYTES = 256,
  parameter int unsigned CNT_W      = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic             last_i,
  input  wire logic [7:0]       data_byte_i,
  output fts_pkg::hdr_t         hdr_o,
  output logic      [CNT_W-1:0] cnt_o
);

  fts_pkg::hdr_t    hdr_q, hdr_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Fold the current byte into the state
  always_comb begin
    hdr_d = hdr_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (idx_q < CNT_W'(SCAN_BYTES)) begin
      if (idx_q < CNT_W'(fts_pkg::HDR_KEEP)) begin
        hdr_d[idx_q[fts_pkg::HDR_IDX_W-1:0]] = data_byte_i;
      end
      if (fts_pkg::is_text(data_byte_i)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      idx_d = idx_q + CNT_W'(1);
    end
  end

  // Clear after the last byte so the next transfer starts a new buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        hdr_q <= '0;
        idx_q <= '0;
        cnt_q <= '0;
      end else begin
        hdr_q <= hdr_d;
        idx_q <= idx_d;
        cnt_q <= cnt_d;
      end
    end
  end

  assign hdr_o = hdr_d;
  assign cnt_o = cnt_d;

endmodule

`default_nettype wire

/* src/fts_classify.sv */
// Magic number match and text/binary decision for one buffer.
// Depends on fts_pkg.
`default_nettype none

module fts_classify #(
  parameter int unsigned CNT_W      = 9,
  parameter int unsigned TEXT_CAP   = 240,
  parameter int unsigned MIN_LENGTH = 16
) (
  input  wire fts_pkg::hdr_t       hdr_i,
  input  wire logic    [CNT_W-1:0] cnt_i,
  input  wire logic    [15:0]      len_i,
  output fts_pkg::type_code_e      code_o
);

  // Wide enough for 10 * count and 9 * length
  localparam int unsigned PW = 21;

  logic [7:0]    b0, b1, b2, b3, b4;
  logic [PW-1:0] cnt_x10;
  logic [PW-1:0] len_x9;
  logic          is_txt;

  assign b0 = hdr_i[0];
  assign b1 = hdr_i[1];
  assign b2 = hdr_i[2];
  assign b3 = hdr_i[3];
  assign b4 = hdr_i[4];

  // count > floor(9*len/10) holds exactly when 10*count > 9*len
  assign cnt_x10 = PW'(cnt_i) * PW'(4'd10);
  assign len_x9  = PW'(len_i) * PW'(4'd9);
  assign is_txt  = (cnt_x10 > len_x9) || (32'(cnt_i) > 32'(TEXT_CAP));

  always_comb begin
    if (len_i < 16'(MIN_LENGTH)) begin
      code_o = fts_pkg::TYPE_UNKNOWN;
    end else if (b0 == fts_pkg::B_FF && b1 == fts_pkg::B_D8 && b2 == fts_pkg::B_FF) begin
      code_o = fts_pkg::TYPE_JPG;
    end else if (b0 == fts_pkg::B_89 && b1 == fts_pkg::B_P &&
                 b2 == fts_pkg::B_N && b3 == fts_pkg::B_G) begin
      code_o = fts_pkg::TYPE_PNG;
    end else if (b0 == fts_pkg::B_PCT && b1 == fts_pkg::B_P && b2 == fts_pkg::B_D &&
                 b3 == fts_pkg::B_F && b4 == fts_pkg::B_DASH) begin
      code_o = fts_pkg::TYPE_PDF;
    end else if (b0 == fts_pkg::B_P && b1 == fts_pkg::B_K &&
                 b2 == fts_pkg::B_03 && b3 == fts_pkg::B_04) begin
      code_o = fts_pkg::TYPE_ZIP;
    end else if (b0 == fts_pkg::B_PCT && b1 == fts_pkg::B_BANG &&
                 b2 == fts_pkg::B_P && b3 == fts_pkg::B_S) begin
      code_o = fts_pkg::TYPE_PS;
    end else if (b0 == fts_pkg::B_G && b1 == fts_pkg::B_I && b2 == fts_pkg::B_F) begin
      code_o = fts_pkg::TYPE_GIF;
    end else if ((b0 == fts_pkg::B_I && b1 == fts_pkg::B_I &&
                  b2 == fts_pkg::B_STAR && b3 == fts_pkg::B_00) ||
                 (b0 == fts_pkg::B_M && b1 == fts_pkg::B_M &&
                  b2 == fts_pkg::B_00 && b3 == fts_pkg::B_STAR)) begin
      code_o = fts_pkg::TYPE_TIF;
    end else if (b0 == fts_pkg::B_DEL && b1 == fts_pkg::B_E &&
                 b2 == fts_pkg::B_L && b3 == fts_pkg::B_F) begin
      code_o = fts_pkg::TYPE_ELF;
    end else if (is_txt) begin
      code_o = fts_pkg::TYPE_TXT;
    end else begin
      code_o = fts_pkg::TYPE_DAT;
    end
  end

endmodule

`default_nettype wire
